>>> src/qsbe_pkg.sv
// ----------------------------------------------------------------------------
// qsbe_pkg: shared types and functions for the quoted string byte escaper
// Holds the operation codes, character constants and the escape function
// that maps one input word to up to four characters of literal text.
// ----------------------------------------------------------------------------
package qsbe_pkg;

    localparam int MaxChars = 4;
    localparam int CountWidth = $clog2(MaxChars + 1);

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [7:0] CH_QUOTE     = 8'd39;
    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_ZERO      = 8'd48;
    localparam logic [7:0] CH_NINE      = 8'd57;
    localparam logic [7:0] PRINT_LOW    = 8'd32;
    localparam logic [7:0] PRINT_HIGH   = 8'd126;

    typedef logic [MaxChars-1:0][7:0] char_buf_t;

    typedef struct packed {
        char_buf_t             chars;
        logic [CountWidth-1:0] count;
        logic                  flag;
    } esc_t;

    function automatic esc_t qsbe_escape(op_t op, logic [7:0] b, logic flag);
        esc_t       res;
        logic       is_digit;
        logic       is_plain;
        logic [1:0] hund;
        logic [6:0] rem;
        logic [14:0] prod;
        logic [3:0] tens;
        logic [3:0] ones;
        res.chars = '0;
        res.count = '0;
        res.flag  = flag;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        is_plain = (b >= PRINT_LOW) && (b <= PRINT_HIGH) && (b != CH_QUOTE) &&
                   (b != CH_BACKSLASH) && !is_digit;
        hund = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
        rem  = 7'(b - 8'(hund) * 8'd100);
        // Multiply by 205 and shift by 11 divides by ten for values below 100.
        prod = 15'(rem) * 15'd205;
        tens = prod[14:11];
        ones = 4'(rem - 7'(tens) * 7'd10);
        case (op)
            OP_START: begin
                res.chars[0] = CH_QUOTE;
                res.count    = CountWidth'(1);
                res.flag     = 1'b0;
            end
            OP_END: begin
                res.chars[0] = CH_QUOTE;
                res.count    = CountWidth'(1);
            end
            OP_DATA: begin
                if (is_plain || (is_digit && !flag)) begin
                    res.chars[0] = b;
                    res.count    = CountWidth'(1);
                    res.flag     = 1'b0;
                end else if (b == CH_BACKSLASH) begin
                    res.chars[0] = CH_BACKSLASH;
                    res.chars[1] = CH_BACKSLASH;
                    res.count    = CountWidth'(2);
                    res.flag     = 1'b0;
                end else begin
                    res.chars[0] = CH_BACKSLASH;
                    res.flag     = 1'b1;
                    if (hund != 2'd0) begin
                        res.chars[1] = CH_ZERO + 8'(hund);
                        res.chars[2] = CH_ZERO + 8'(tens);
                        res.chars[3] = CH_ZERO + 8'(ones);
                        res.count    = CountWidth'(4);
                    end else if (tens != 4'd0) begin
                        res.chars[1] = CH_ZERO + 8'(tens);
                        res.chars[2] = CH_ZERO + 8'(ones);
                        res.count    = CountWidth'(3);
                    end else begin
                        res.chars[1] = CH_ZERO + 8'(ones);
                        res.count    = CountWidth'(2);
                    end
                end
            end
            default: begin
                res.count = '0;
            end
        endcase
        return res;
    endfunction

endpackage

>>> src/quoted_string_byte_escaper.sv
// ----------------------------------------------------------------------------
// quoted_string_byte_escaper: single-quoted literal text from a byte stream
// Each input word is escaped in one pass and its characters drain from a
// small output buffer, one character per output word.
// ----------------------------------------------------------------------------
// The slave channel takes one word per byte: s_tdata carries the byte and
// s_tuser the operation (data, start of string, end of string; the fourth
// code is taken and dropped). The master channel gives one character per
// word on m_tdata, with m_tlast high on the final character of each input.
// A word is escaped in the cycle it is accepted and its first character is
// valid in the next cycle. A word yields up to four characters and the
// block takes one input word per cycle whenever each input yields a single
// character and the receiver is ready; otherwise input waits while the
// output buffer drains. A new word is taken in the same cycle that the
// final pending character leaves. When the receiver stalls, the buffer
// holds its characters and input stops until the buffer is empty or its
// final character is taken.
// Reset empties the buffer and clears the flag that marks a preceding
// decimal escape.
// ----------------------------------------------------------------------------
module quoted_string_byte_escaper
    import qsbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);

    char_buf_t             chars_reg, chars_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  flag_reg, flag_next;
    logic                  s_accept;
    logic                  m_accept;
    esc_t                  esc;

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = chars_reg[0];
    assign m_tlast  = (count_reg == CountWidth'(1));
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = (count_reg == '0) || (m_tlast && m_tready);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        esc        = qsbe_escape(op_t'(s_tuser), s_tdata, flag_reg);
        chars_next = chars_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        if (s_accept) begin
            chars_next = esc.chars;
            count_next = esc.count;
            flag_next  = esc.flag;
        end else if (m_accept) begin
            chars_next = {8'd0, chars_reg[MaxChars-1:1]};
            count_next = count_reg - CountWidth'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
        chars_reg <= chars_next;
    end

`ifndef NO_ASSERTIONS
    // A start word always shows its quote alone in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser == OP_START) |=> m_tvalid && m_tlast && (m_tdata == CH_QUOTE))
        else $error("start word did not produce a lone quote");

    // No input is taken while characters other than the final one remain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid || m_tlast)
        else $error("input accepted with more than one character pending");

    // A control byte always leaves the decimal escape flag set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser == OP_DATA) && (s_tdata < PRINT_LOW) |=> flag_reg)
        else $error("decimal escape flag not set after control byte");
`endif

endmodule
